@@ sv/rvbb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the rounding helper for the rotated vertex box core.
// No dependencies; every other file imports this package.
package rvbb_pkg;

	localparam int TRIG_FRAC_BITS = 14;   // Q2.14 sine and cosine
	localparam int COORD_W        = 31;   // rotated coordinate width
	localparam int VERT_W         = 30;   // input coordinate width
	localparam int TRIG_W         = 16;
	localparam int PROD_W         = COORD_W + TRIG_W;
	localparam int SUM_W          = PROD_W + 2;
	localparam int CFG_IDX_W      = 3;

	localparam logic [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1 << TRIG_FRAC_BITS);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [VERT_W-1:0]  vert_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COS_X = 3'd0,
		REG_SIN_X = 3'd1,
		REG_COS_Y = 3'd2,
		REG_SIN_Y = 3'd3,
		REG_COS_Z = 3'd4,
		REG_SIN_Z = 3'd5
	} reg_idx_t;

	typedef struct packed {
		trig_t cos_x;
		trig_t sin_x;
		trig_t cos_y;
		trig_t sin_y;
		trig_t cos_z;
		trig_t sin_z;
	} trig_cfg_t;

	// one rotated vertex as it crosses the queue
	typedef struct packed {
		logic   last;
		coord_t z;
		coord_t y;
		coord_t x;
	} rot_vtx_t;

	typedef struct packed {
		logic [COORD_W-1:0] size_z;
		logic [COORD_W-1:0] size_y;
		logic [COORD_W-1:0] size_x;
		coord_t             center_z;
		coord_t             center_y;
		coord_t             center_x;
	} box_t;

	localparam sum_t HALF_LSB  = sum_t'(1) <<< (TRIG_FRAC_BITS - 1);
	localparam sum_t COORD_MAX = sum_t'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
	localparam sum_t COORD_MIN = -sum_t'(64'sd1 <<< (COORD_W - 1));

	// round half up, drop the trig fraction, clamp to the coordinate range
	function automatic coord_t rnd_sat(input sum_t s);
		sum_t q;
		q = (s + HALF_LSB) >>> TRIG_FRAC_BITS;
		if (q > COORD_MAX) begin
			return COORD_MAX[COORD_W-1:0];
		end else if (q < COORD_MIN) begin
			return COORD_MIN[COORD_W-1:0];
		end
		return q[COORD_W-1:0];
	endfunction

endpackage

@@ sv/rvbb_rotate.sv @@
`timescale 1ns / 1ps
// Front part: six-stage rotation pipeline (X, then Y, then Z axis).
// Depends on rvbb_pkg.
module rvbb_rotate (
	input  logic               clk,
	input  logic               arst_n,
	input  rvbb_pkg::trig_cfg_t cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  rvbb_pkg::vert_t    in_x,
	input  rvbb_pkg::vert_t    in_y,
	input  rvbb_pkg::vert_t    in_z,
	input  logic               in_last,
	output logic               out_valid,
	input  logic               out_ready,
	output rvbb_pkg::rot_vtx_t out_vtx
);
	import rvbb_pkg::*;

	logic   en;
	logic   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic   last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	coord_t x_s1, x_s2, y1_s3, y1_s4, z2_s5;
	prod_t  pa_s1, pb_s1, pc_s1, pd_s1;
	prod_t  pa_s3, pb_s3, pc_s3, pd_s3;
	prod_t  pa_s5, pb_s5, pc_s5, pd_s5;
	coord_t y1_s2, z1_s2, z2_s4, x2_s4;
	coord_t xr_s6, yr_s6, zr_s6;
	coord_t in_xe, in_ye, in_ze;

	// advance the whole pipe unless the tail is blocked
	assign en       = !v_s6 || out_ready;
	assign in_ready = en;

	assign in_xe = coord_t'(in_x);
	assign in_ye = coord_t'(in_y);
	assign in_ze = coord_t'(in_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// X axis products
			pa_s1   <= in_ye * cfg.cos_x;
			pb_s1   <= in_ze * cfg.sin_x;
			pc_s1   <= in_ye * cfg.sin_x;
			pd_s1   <= in_ze * cfg.cos_x;
			x_s1    <= in_xe;
			last_s1 <= in_last;
			// X axis sums
			y1_s2   <= rnd_sat(sum_t'(pa_s1) - sum_t'(pb_s1));
			z1_s2   <= rnd_sat(sum_t'(pc_s1) + sum_t'(pd_s1));
			x_s2    <= x_s1;
			last_s2 <= last_s1;
			// Y axis products
			pa_s3   <= z1_s2 * cfg.cos_y;
			pb_s3   <= x_s2 * cfg.sin_y;
			pc_s3   <= z1_s2 * cfg.sin_y;
			pd_s3   <= x_s2 * cfg.cos_y;
			y1_s3   <= y1_s2;
			last_s3 <= last_s2;
			// Y axis sums
			z2_s4   <= rnd_sat(sum_t'(pa_s3) - sum_t'(pb_s3));
			x2_s4   <= rnd_sat(sum_t'(pc_s3) + sum_t'(pd_s3));
			y1_s4   <= y1_s3;
			last_s4 <= last_s3;
			// Z axis products
			pa_s5   <= x2_s4 * cfg.cos_z;
			pb_s5   <= y1_s4 * cfg.sin_z;
			pc_s5   <= x2_s4 * cfg.sin_z;
			pd_s5   <= y1_s4 * cfg.cos_z;
			z2_s5   <= z2_s4;
			last_s5 <= last_s4;
			// Z axis sums
			xr_s6   <= rnd_sat(sum_t'(pa_s5) - sum_t'(pb_s5));
			yr_s6   <= rnd_sat(sum_t'(pc_s5) + sum_t'(pd_s5));
			zr_s6   <= z2_s5;
			last_s6 <= last_s5;
		end
	end

	assign out_valid    = v_s6;
	assign out_vtx.x    = xr_s6;
	assign out_vtx.y    = yr_s6;
	assign out_vtx.z    = zr_s6;
	assign out_vtx.last = last_s6;

endmodule

@@ sv/rvbb_queue.sv @@
`timescale 1ns / 1ps
// Small FIFO of rotated vertices between the rotation pipe and the bounds unit.
// Depends on rvbb_pkg.
module rvbb_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               wr_ready,
	input  rvbb_pkg::rot_vtx_t wr_data,
	output logic               rd_valid,
	input  logic               rd_ready,
	output rvbb_pkg::rot_vtx_t rd_data
);
	import rvbb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	rot_vtx_t         mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign wr_ready = (count_q != FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/rvbb_bound.sv @@
`timescale 1ns / 1ps
// Back part: running min/max of rotated vertices and the box result register.
// Depends on rvbb_pkg.
module rvbb_bound (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rvbb_pkg::rot_vtx_t in_vtx,
	output logic               out_valid,
	input  logic               out_ready,
	output rvbb_pkg::box_t     out_box
);
	import rvbb_pkg::*;

	coord_t low_x_q, low_y_q, low_z_q, high_x_q, high_y_q, high_z_q;
	logic   seen_q, fin_q, out_valid_q;
	logic   take, emit;
	logic signed [COORD_W:0] mid_x, mid_y, mid_z;
	box_t   box_d, box_q;

	// hold new vertices while a finished set waits to be turned into a box
	assign in_ready = !fin_q;
	assign take     = in_valid && !fin_q;
	assign emit     = fin_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (take) begin
			if (!seen_q || in_vtx.x < low_x_q)  low_x_q  <= in_vtx.x;
			if (!seen_q || in_vtx.y < low_y_q)  low_y_q  <= in_vtx.y;
			if (!seen_q || in_vtx.z < low_z_q)  low_z_q  <= in_vtx.z;
			if (!seen_q || in_vtx.x > high_x_q) high_x_q <= in_vtx.x;
			if (!seen_q || in_vtx.y > high_y_q) high_y_q <= in_vtx.y;
			if (!seen_q || in_vtx.z > high_z_q) high_z_q <= in_vtx.z;
		end
		if (emit) begin
			box_q <= box_d;
		end
	end

	always_comb begin
		mid_x = (COORD_W+1)'(low_x_q) + (COORD_W+1)'(high_x_q);
		mid_y = (COORD_W+1)'(low_y_q) + (COORD_W+1)'(high_y_q);
		mid_z = (COORD_W+1)'(low_z_q) + (COORD_W+1)'(high_z_q);
		box_d.center_x = mid_x[COORD_W:1];
		box_d.center_y = mid_y[COORD_W:1];
		box_d.center_z = mid_z[COORD_W:1];
		box_d.size_x   = COORD_W'(high_x_q - low_x_q);
		box_d.size_y   = COORD_W'(high_y_q - low_y_q);
		box_d.size_z   = COORD_W'(high_z_q - low_z_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				seen_q <= !in_vtx.last;
				fin_q  <= in_vtx.last;
			end else if (emit) begin
				fin_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_box   = box_q;

endmodule

@@ sv/rotated_vertex_bounding_box_core.sv @@
`timescale 1ns / 1ps
// Top level of the rotated vertex bounding box core: config registers,
// rotation front end, vertex queue and bounds back end. Depends on rvbb_pkg,
// rvbb_rotate, rvbb_queue and rvbb_bound.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  s_*      | s_tvalid / s_tready    | s_tdata vertex x,y,z; s_tlast = last vertex
//  m_*      | m_tvalid / m_tready    | m_tdata box center x,y,z then size x,y,z
//  cfg_*    | cfg_valid / cfg_ready  | cfg_index register, cfg_data 16-bit value
//
// A vertex request enters every cycle while the pipe can move. It crosses the six
// rotation stages, is written into the queue and is then taken by the bounds unit.
// After a last vertex the box enters the output register once that register is free;
// the bounds unit refuses input until it does.
// Reset clears all control state and loads identity rotation (cos 1, sin 0).
// A stalled output holds the box; the queue soaks up the rotation pipe, and
// when it fills, s_tready drops and the pipe holds in place.
module rotated_vertex_bounding_box_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // vert_x[29:0], vert_y[59:30], vert_z[89:60], zero pad
	input  logic         s_tlast,   // last_vertex
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,   // center_x, center_y, center_z, size_x, size_y, size_z
	                                // (31 bits each from bit 0 up), zero pad
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [rvbb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]  cfg_data
);
	import rvbb_pkg::*;

	trig_cfg_t trig_q;
	logic      rot_valid, rot_ready, q_valid, q_ready;
	rot_vtx_t  rot_vtx, q_vtx;
	box_t      box;
	reg_idx_t  idx;

	// registers take writes at any time; the host must write them only when idle
	assign cfg_ready = 1'b1;
	assign idx       = reg_idx_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q.cos_x <= TRIG_ONE;
			trig_q.sin_x <= '0;
			trig_q.cos_y <= TRIG_ONE;
			trig_q.sin_y <= '0;
			trig_q.cos_z <= TRIG_ONE;
			trig_q.sin_z <= '0;
		end else if (cfg_valid) begin
			unique case (idx)
				REG_COS_X: trig_q.cos_x <= cfg_data;
				REG_SIN_X: trig_q.sin_x <= cfg_data;
				REG_COS_Y: trig_q.cos_y <= cfg_data;
				REG_SIN_Y: trig_q.sin_y <= cfg_data;
				REG_COS_Z: trig_q.cos_z <= cfg_data;
				REG_SIN_Z: trig_q.sin_z <= cfg_data;
				default: ;   // drop writes to unmapped indexes
			endcase
		end
	end

	rvbb_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (trig_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_x      (s_tdata[29:0]),
		.in_y      (s_tdata[59:30]),
		.in_z      (s_tdata[89:60]),
		.in_last   (s_tlast),
		.out_valid (rot_valid),
		.out_ready (rot_ready),
		.out_vtx   (rot_vtx)
	);

	rvbb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (rot_valid),
		.wr_ready (rot_ready),
		.wr_data  (rot_vtx),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_vtx)
	);

	rvbb_bound u_bound (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_vtx    (q_vtx),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_box   (box)
	);

	// pack the box with center_x in the lowest bits
	assign m_tdata = {6'b0, box};

endmodule

@@ verif/rvbb_checker.sv @@
`timescale 1ns / 1ps
// Box checker for the rotated vertex bounding box core: watches the vertex, box and
// register channels, predicts every box and compares it field by field. Depends on rvbb_pkg.
module rvbb_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [95:0]                    s_tdata,
	input  logic                           s_tlast,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [191:0]                   m_tdata,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [rvbb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	output int                             fail_count,
	output int                             boxes_pending
);
	import rvbb_pkg::*;

	localparam longint ROT_HI     = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
	localparam longint ROT_LO     = -(64'sd1 <<< (COORD_W - 1));
	localparam int     REPORT_MAX = 10;

	longint rot_cos [3];
	longint rot_sin [3];
	longint bound_lo [3];
	longint bound_hi [3];
	longint rv [3];
	bit     set_open;
	box_t   box_queue [$];
	box_t   want_box;
	box_t   got_box;
	box_t   new_box;
	int     fails = 0;

	// two products in Q2.14 scaling, rounded half up, clamped to 31 bits
	function automatic longint trig_mac(longint a, longint p, longint b, longint q);
		longint s;
		s = (a * p + b * q + (64'sd1 <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
		if (s > ROT_HI)
			return ROT_HI;
		if (s < ROT_LO)
			return ROT_LO;
		return s;
	endfunction

	// X, then Y, then Z; result lands in rv
	function automatic void rotate_vertex(longint vx, longint vy, longint vz);
		longint y1;
		longint z1;
		longint x2;
		y1 = trig_mac(vy, rot_cos[0], vz, -rot_sin[0]);
		z1 = trig_mac(vy, rot_sin[0], vz, rot_cos[0]);
		rv[2] = trig_mac(z1, rot_cos[1], vx, -rot_sin[1]);
		x2 = trig_mac(z1, rot_sin[1], vx, rot_cos[1]);
		rv[0] = trig_mac(x2, rot_cos[2], y1, -rot_sin[2]);
		rv[1] = trig_mac(x2, rot_sin[2], y1, rot_cos[2]);
	endfunction

	task automatic check_field(string name, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
		if (want !== got) begin
			if (fails < REPORT_MAX)
				$display("box %s mismatch: expected 0x%08h got 0x%08h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				rot_cos[a] = 64'sd1 <<< TRIG_FRAC_BITS;
				rot_sin[a] = 0;
			end
			set_open = 1'b0;
			box_queue.delete();
			boxes_pending <= 0;
			fail_count <= fails;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COS_X: rot_cos[0] = longint'($signed(cfg_data));
					REG_SIN_X: rot_sin[0] = longint'($signed(cfg_data));
					REG_COS_Y: rot_cos[1] = longint'($signed(cfg_data));
					REG_SIN_Y: rot_sin[1] = longint'($signed(cfg_data));
					REG_COS_Z: rot_cos[2] = longint'($signed(cfg_data));
					REG_SIN_Z: rot_sin[2] = longint'($signed(cfg_data));
					default: ;
				endcase
			end

			if (m_tvalid && m_tready) begin
				got_box = box_t'(m_tdata[$bits(box_t)-1:0]);
				if (box_queue.size() == 0) begin
					if (fails < REPORT_MAX)
						$display("unexpected box: 0x%h", m_tdata[$bits(box_t)-1:0]);
					fails++;
				end else begin
					want_box = box_queue.pop_front();
					check_field("center_x", want_box.center_x, got_box.center_x);
					check_field("center_y", want_box.center_y, got_box.center_y);
					check_field("center_z", want_box.center_z, got_box.center_z);
					check_field("size_x", want_box.size_x, got_box.size_x);
					check_field("size_y", want_box.size_y, got_box.size_y);
					check_field("size_z", want_box.size_z, got_box.size_z);
				end
			end

			if (s_tvalid && s_tready) begin
				rotate_vertex(longint'($signed(s_tdata[29:0])),
				              longint'($signed(s_tdata[59:30])),
				              longint'($signed(s_tdata[89:60])));
				// the first vertex of a set seeds both bounds
				for (int a = 0; a < 3; a++) begin
					if (!set_open || rv[a] < bound_lo[a])
						bound_lo[a] = rv[a];
					if (!set_open || rv[a] > bound_hi[a])
						bound_hi[a] = rv[a];
				end
				set_open = 1'b1;
				if (s_tlast) begin
					new_box.center_x = coord_t'((bound_lo[0] + bound_hi[0]) >>> 1);
					new_box.center_y = coord_t'((bound_lo[1] + bound_hi[1]) >>> 1);
					new_box.center_z = coord_t'((bound_lo[2] + bound_hi[2]) >>> 1);
					new_box.size_x   = COORD_W'(bound_hi[0] - bound_lo[0]);
					new_box.size_y   = COORD_W'(bound_hi[1] - bound_lo[1]);
					new_box.size_z   = COORD_W'(bound_hi[2] - bound_lo[2]);
					box_queue.push_back(new_box);
					set_open = 1'b0;
				end
			end

			fail_count <= fails;
			boxes_pending <= box_queue.size();
		end
	end

endmodule

@@ verif/tb_rotated_vertex_bounding_box_core.sv @@
`timescale 1ns / 1ps
// Testbench top for rotated_vertex_bounding_box_core: drives vertex sets, register
// writes and output back-pressure, and gives the verdict. Depends on rvbb_pkg, the
// core and rvbb_checker.
module tb_rotated_vertex_bounding_box_core;
	import rvbb_pkg::*;

	// vertex coordinates, Q14.16 in 30 bits
	localparam logic [VERT_W-1:0] V_MAX  = 30'h1FFF_FFFF;
	localparam logic [VERT_W-1:0] V_MIN  = 30'h2000_0000;
	localparam logic [VERT_W-1:0] V_ONE  = 30'h0001_0000;
	localparam logic [VERT_W-1:0] V_ZERO = 30'h0000_0000;
	// trig values, Q2.14 in 16 bits; the raw extremes lie past +-1.0
	localparam logic [15:0] T_ZERO    = 16'h0000;
	localparam logic [15:0] T_ONE     = 16'h4000;
	localparam logic [15:0] T_NEG_ONE = 16'hC000;
	localparam logic [15:0] T_HALF    = 16'h2000;
	localparam logic [15:0] T_RAW_MAX = 16'h7FFF;
	localparam logic [15:0] T_RAW_MIN = 16'h8000;
	// register indexes past the last trig register; the core must ignore them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 40;
	localparam int DRAIN_CYCLES = 20;      // covers rotation pipe, queue and box stage
	localparam int CYCLE_LIMIT  = 500000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [95:0]          s_tdata   = '0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [191:0]         m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data  = '0;

	int box_fails;
	int boxes_pending;
	int cycles     = 0;
	int sent       = 0;
	int ready_gap;
	bit no_idle    = 1'b0;   // set for phases that run back to back with no gaps

	always #5 clk = ~clk;

	rotated_vertex_bounding_box_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rvbb_checker u_box_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (box_fails),
		.boxes_pending (boxes_pending)
	);

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Coordinate mix: extremes, small values near the origin, full-range noise.
	function automatic logic [VERT_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return V_MAX;
			1: return V_MIN;
			2, 3: return VERT_W'(int'($urandom_range(0, 4194304)) - 2097152);
			default: return VERT_W'($urandom());
		endcase
	endfunction

	// Trig value by style: in range, any 16 bits, right angles, or the extremes.
	function automatic logic [15:0] rand_trig(input int style);
		case (style)
			0: return 16'(int'($urandom_range(0, 32768)) - 16384);
			1: return 16'($urandom());
			2: begin
				case ($urandom_range(0, 2))
					0: return T_ZERO;
					1: return T_ONE;
					default: return T_NEG_ONE;
				endcase
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return T_RAW_MAX;
					1: return T_RAW_MIN;
					2: return T_ONE;
					default: return T_NEG_ONE;
				endcase
			end
		endcase
	endfunction

	// Offer one vertex request after a random gap and hold it until taken. Leave
	// tvalid high afterwards so the next request can follow in the very next cycle.
	task automatic send_vertex(input logic [VERT_W-1:0] x, input logic [VERT_W-1:0] y,
	                           input logic [VERT_W-1:0] z, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, z, y, x};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_rotation(input logic [15:0] cx, input logic [15:0] sx,
	                            input logic [15:0] cy, input logic [15:0] sy,
	                            input logic [15:0] cz, input logic [15:0] sz);
		cfg_write(REG_COS_X, cx);
		cfg_write(REG_SIN_X, sx);
		cfg_write(REG_COS_Y, cy);
		cfg_write(REG_SIN_Y, sy);
		cfg_write(REG_COS_Z, cz);
		cfg_write(REG_SIN_Z, sz);
	endtask

	// Hold the sender until every predicted box has come out, then let the pipe
	// settle so a register write cannot overtake a vertex still in flight.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (boxes_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Output back-pressure: ready cycles mixed with stalls of random length.
	initial begin
		@(posedge clk);
		forever begin
			ready_gap = pick_gap();
			if (ready_gap == 0) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (ready_gap) @(posedge clk);
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int set_len;
		int style;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity rotation straight out of reset: single-vertex sets give the
		// vertex itself with zero size, then a set spanning the full range.
		send_vertex(V_ZERO, V_ZERO, V_ZERO, 1'b1);
		send_vertex(V_MAX, V_MIN, V_MAX, 1'b1);
		send_vertex(V_MAX, V_MAX, V_MAX, 1'b0);
		send_vertex(V_MIN, V_MIN, V_MIN, 1'b0);
		send_vertex(30'd1, -30'd1, V_ZERO, 1'b1);
		wait_idle();

		// Trig past +-1.0 on every axis: drive every stage into saturation.
		// Write the spare indexes too; they must leave the rotation alone.
		set_rotation(T_RAW_MAX, T_RAW_MIN, T_RAW_MAX, T_RAW_MIN, T_RAW_MAX, T_RAW_MIN);
		cfg_write(CFG_SPARE_LO, 16'hFFFF);
		cfg_write(CFG_SPARE_HI, 16'h0000);
		send_vertex(V_MAX, V_MAX, V_MAX, 1'b0);
		send_vertex(V_MIN, V_MIN, V_MIN, 1'b0);
		send_vertex(V_MAX, V_MIN, V_MAX, 1'b1);
		send_vertex(V_MIN, V_MAX, V_MIN, 1'b1);
		wait_idle();

		// Quarter turns about each axis: unit vectors trade places.
		set_rotation(T_ZERO, T_ONE, T_ZERO, T_ONE, T_ZERO, T_ONE);
		send_vertex(V_ONE, V_ZERO, V_ZERO, 1'b0);
		send_vertex(V_ZERO, V_ONE, V_ZERO, 1'b0);
		send_vertex(V_ZERO, V_ZERO, V_ONE, 1'b1);
		wait_idle();

		// Negative cosine; odd bounds exercise the floor in the center.
		set_rotation(T_NEG_ONE, T_ONE, T_NEG_ONE, T_ONE, T_NEG_ONE, T_ONE);
		send_vertex(-30'd1, -30'd1, -30'd1, 1'b0);
		send_vertex(30'd1, 30'd3, 30'd5, 1'b0);
		send_vertex(V_MIN, V_ZERO, V_MAX, 1'b1);
		wait_idle();

		// Half scale: +0.5 and -0.5 products test the round-half-up step.
		set_rotation(T_HALF, T_ZERO, T_HALF, T_ZERO, T_HALF, T_ZERO);
		send_vertex(30'd1, -30'd1, 30'd3, 1'b0);
		send_vertex(-30'd3, 30'd1, -30'd1, 1'b1);
		wait_idle();

		// Random phases: fresh rotation, sometimes a spare-index write, then well-formed sets of random length.
		for (int ph = 0; ph < PHASES; ph++) begin
			style = ph % 4;
			no_idle = (ph == 3 || ph == 7);
			set_rotation(rand_trig(style), rand_trig(style), rand_trig(style),
			             rand_trig(style), rand_trig(style), rand_trig(style));
			if ($urandom_range(0, 3) == 0)
				cfg_write(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
				          16'($urandom()));
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				case ($urandom_range(0, 19))
					0: set_len = 1;
					1, 2, 3, 4: set_len = $urandom_range(7, 20);
					default: set_len = $urandom_range(1, 6);
				endcase
				for (int i = 0; i < set_len; i++)
					send_vertex(rand_coord(), rand_coord(), rand_coord(), i == set_len - 1);
			end
			wait_idle();
		end
		no_idle = 1'b0;

		if (box_fails == 0 && boxes_pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
